// ----- sv/rcdf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcdf_pkg
// Shared types, constants and the microcode ROM of the RSSI charge/discharge
// filter.
// ----------------------------------------------------------------------------
package rcdf_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register reset values
    localparam int CEILING_RESET   = 135;
    localparam int FILTER_RESET    = 256;
    localparam int FILTER_W        = 16;

    // Configuration register indexes
    localparam logic REG_SAMPLE_CEILING  = 1'b0;
    localparam logic REG_FILTER_CONSTANT = 1'b1;

    // Percent division: 7 quotient bits, 6 low dividend bits shifted in
    localparam int PCT_W     = 7;
    localparam int PCT_STEPS = 7;
    localparam int PCT_LOW   = 6;
    localparam int PCT_MAX   = 100;
    localparam int PCT_SCALE = 200;

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_LOAD     = 4'd1,
        OP_DIV_ON   = 4'd2,
        OP_DIV_OFF  = 4'd3,
        OP_DIV_STEP = 4'd4,
        OP_SAVE_ON  = 4'd5,
        OP_SAVE_OFF = 4'd6,
        OP_MUL_ON   = 4'd7,
        OP_L1       = 4'd8,
        OP_MUL_OFF  = 4'd9,
        OP_LEVEL    = 4'd10,
        OP_PEAK     = 4'd11,
        OP_DIV_PCT  = 4'd12,
        OP_EMIT     = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        C_TRUE     = 3'd0,
        C_FALSE    = 3'd1,
        C_IN_VALID = 3'd2,
        C_OUT_FREE = 3'd3,
        C_DIV_MORE = 3'd4
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           wait_c;   // stall here until true
        cond_t           jump_c;   // jump to target when true
        logic [PC_W-1:0] target;
    } uword_t;

    // Control word handed to the datapath
    typedef struct packed {
        op_t  op;
        logic en;
    } ctrl_t;

    // Condition inputs to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_more;
    } stat_t;

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, wait_c: C_TRUE, jump_c: C_FALSE, target: '0};
        case (pc)
            4'd0:  w = '{op: OP_LOAD,     wait_c: C_IN_VALID, jump_c: C_FALSE,    target: 4'd0};
            4'd1:  w = '{op: OP_DIV_ON,   wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd2:  w = '{op: OP_DIV_STEP, wait_c: C_TRUE,     jump_c: C_DIV_MORE, target: 4'd2};
            4'd3:  w = '{op: OP_SAVE_ON,  wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd4:  w = '{op: OP_DIV_OFF,  wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd5:  w = '{op: OP_DIV_STEP, wait_c: C_TRUE,     jump_c: C_DIV_MORE, target: 4'd5};
            4'd6:  w = '{op: OP_SAVE_OFF, wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd7:  w = '{op: OP_MUL_ON,   wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd8:  w = '{op: OP_L1,       wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd9:  w = '{op: OP_MUL_OFF,  wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd10: w = '{op: OP_LEVEL,    wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd11: w = '{op: OP_PEAK,     wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd12: w = '{op: OP_DIV_PCT,  wait_c: C_TRUE,     jump_c: C_FALSE,    target: 4'd0};
            4'd13: w = '{op: OP_DIV_STEP, wait_c: C_TRUE,     jump_c: C_DIV_MORE, target: 4'd13};
            4'd14: w = '{op: OP_EMIT,     wait_c: C_OUT_FREE, jump_c: C_TRUE,     target: 4'd0};
            default: w = '{op: OP_NOP,    wait_c: C_TRUE,     jump_c: C_TRUE,     target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/rcdf_div.sv -----
// ----------------------------------------------------------------------------
// rcdf_div
// Shared restoring divider, one quotient bit per step. The partial remainder
// is compared first, then shifted with the next low dividend bit.
// ----------------------------------------------------------------------------
module rcdf_div
    import rcdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int DEN_W = ((SAMPLE_BITS + 9) > (FRAC_BITS + 2)) ?
                           (SAMPLE_BITS + 9) : (FRAC_BITS + 2),
    localparam int DIV_W = DEN_W + 1,
    localparam int Q_W   = FRAC_BITS + 1,
    localparam int CNT_W = $clog2(FRAC_BITS + 2)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               step,
    input  logic [DIV_W-1:0]   rem_init,
    input  logic [PCT_LOW-1:0] low_init,
    input  logic [DEN_W-1:0]   den,
    input  logic [CNT_W-1:0]   nsteps,
    output logic [Q_W-1:0]     quotient,
    output logic               more
);

    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [PCT_LOW-1:0] low_reg, low_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ge;
    logic [DIV_W-1:0]   diff;

    always_comb
    begin
        ge       = rem_reg >= {1'b0, den_reg};
        diff     = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        den_next = den_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = rem_init;
            low_next = low_init;
            den_next = den;
            q_next   = '0;
            cnt_next = nsteps;
        end
        else if (step)
        begin
            rem_next = {diff[DIV_W-2:0], low_reg[PCT_LOW-1]};
            low_next = {low_reg[PCT_LOW-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign more     = cnt_reg > CNT_W'(1);

endmodule

// ----- sv/rcdf_datapath.sv -----
// ----------------------------------------------------------------------------
// rcdf_datapath
// Filter datapath: clamp, alpha divisions, one shared multiplier, level and
// peak registers, percent division. One control word per cycle when enabled.
// ----------------------------------------------------------------------------
module rcdf_datapath
    import rcdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int LVL_W = FRAC_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl,
    input  logic [SAMPLE_BITS-1:0] sample_ceiling,
    input  logic [FILTER_W-1:0]    filter_constant,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   div_more,
    output logic [LVL_W-1:0]       out_level,
    output logic [PCT_W-1:0]       out_pct
);

    localparam int NUM_W  = SAMPLE_BITS + 8;
    localparam int DEN_W  = ((SAMPLE_BITS + 9) > (FRAC_BITS + 2)) ?
                            (SAMPLE_BITS + 9) : (FRAC_BITS + 2);
    localparam int DIV_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 2);
    localparam int PROD_W = 2 * LVL_W;
    localparam int PNUM_W = LVL_W + 8;
    localparam longint THRESH_I = ((longint'(1) << FRAC_BITS) + 50) / 100;
    localparam logic [LVL_W-1:0]  ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LVL_W-1:0]  THRESH = LVL_W'(THRESH_I);
    localparam logic [PROD_W-1:0] HALF   = PROD_W'(longint'(1) << (FRAC_BITS - 1));

    logic [SAMPLE_BITS-1:0] on_reg, off_reg;
    logic [LVL_W-1:0]       a_on_reg, a_off_reg, l1_reg, level_reg, peak_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   dz_reg;

    logic [SAMPLE_BITS-1:0] x_clamp;
    logic [SAMPLE_BITS-1:0] x_sel;
    logic [NUM_W-1:0]       anum;
    logic [DEN_W-1:0]       aden;
    logic [LVL_W-1:0]       shown;
    logic [PNUM_W-1:0]      pnum;
    logic [LVL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      prod_next;
    logic [PROD_W-1:0]      rnd_wide;
    logic [LVL_W-1:0]       rnd;
    logic [LVL_W:0]         l1_sum;
    logic                   is_pct;
    logic                   div_start, div_step;
    logic [DIV_W-1:0]       rem_init;
    logic [PCT_LOW-1:0]     low_init;
    logic [DEN_W-1:0]       den;
    logic [CNT_W-1:0]       nsteps;
    logic [LVL_W-1:0]       quotient;

    always_comb
    begin
        x_clamp  = (in_sample < sample_ceiling) ? in_sample : sample_ceiling;
        x_sel    = (ctrl.op == OP_DIV_ON) ? on_reg : off_reg;
        anum     = {x_sel, 8'd0};
        aden     = DEN_W'(anum) + DEN_W'(filter_constant);
        shown    = (level_reg <= THRESH) ? '0 : level_reg;
        pnum     = PNUM_W'(shown) * PNUM_W'(PCT_SCALE) + PNUM_W'(peak_reg);
        is_pct   = ctrl.op == OP_DIV_PCT;
        div_start = ctrl.en && (ctrl.op == OP_DIV_ON || ctrl.op == OP_DIV_OFF || is_pct);
        div_step  = ctrl.en && (ctrl.op == OP_DIV_STEP);
        if (is_pct)
        begin
            rem_init = DIV_W'(pnum >> PCT_LOW);
            low_init = pnum[PCT_LOW-1:0];
            den      = DEN_W'({peak_reg, 1'b0});
            nsteps   = CNT_W'(PCT_STEPS);
        end
        else
        begin
            rem_init = DIV_W'(anum);
            low_init = '0;
            den      = aden;
            nsteps   = CNT_W'(FRAC_BITS + 1);
        end
        mul_a     = ONE - ((ctrl.op == OP_MUL_ON) ? a_on_reg : a_off_reg);
        mul_b     = (ctrl.op == OP_MUL_ON) ? level_reg : l1_reg;
        prod_next = mul_a * mul_b;
        rnd_wide  = (prod_reg + HALF) >> FRAC_BITS;
        rnd       = rnd_wide[LVL_W-1:0];
        l1_sum    = {1'b0, a_on_reg} + {1'b0, rnd};
    end

    rcdf_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .step     (div_step),
        .rem_init (rem_init),
        .low_init (low_init),
        .den      (den),
        .nsteps   (nsteps),
        .quotient (quotient),
        .more     (div_more)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            peak_reg  <= THRESH;
        end
        else if (ctrl.en)
        begin
            case (ctrl.op)
                OP_LEVEL:
                begin
                    level_reg <= (rnd > ONE) ? ONE : rnd;
                end
                OP_PEAK:
                begin
                    if (level_reg > peak_reg)
                        peak_reg <= level_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    on_reg  <= x_clamp;
                    off_reg <= sample_ceiling - x_clamp;
                end
                OP_DIV_ON, OP_DIV_OFF:
                begin
                    // zero divisor: alpha is taken as zero
                    dz_reg <= aden == '0;
                end
                OP_SAVE_ON:  a_on_reg  <= dz_reg ? '0 : quotient;
                OP_SAVE_OFF: a_off_reg <= dz_reg ? '0 : quotient;
                OP_MUL_ON, OP_MUL_OFF:
                begin
                    prod_reg <= prod_next;
                end
                OP_L1:
                begin
                    l1_reg <= (l1_sum > {1'b0, ONE}) ? ONE : l1_sum[LVL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_level = shown;
    assign out_pct   = (quotient > LVL_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quotient[PCT_W-1:0];

endmodule

// ----- sv/rcdf_sequencer.sv -----
// ----------------------------------------------------------------------------
// rcdf_sequencer
// Step counter over the microcode ROM with stall and jump conditions.
// ----------------------------------------------------------------------------
module rcdf_sequencer
    import rcdf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            go;
    logic            jump;

    function automatic logic cond_eval(input cond_t c, input stat_t s);
        logic r;
        case (c)
            C_TRUE:     r = 1'b1;
            C_FALSE:    r = 1'b0;
            C_IN_VALID: r = s.in_valid;
            C_OUT_FREE: r = s.out_free;
            C_DIV_MORE: r = s.div_more;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        word = ucode_rom(pc_reg);
        go   = cond_eval(word.wait_c, stat);
        jump = cond_eval(word.jump_c, stat);
        if (!go)
            pc_next = pc_reg;
        else if (jump)
            pc_next = word.target;
        else
            pc_next = pc_reg + 1'b1;
        ctrl.op = word.op;
        ctrl.en = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

// ----- sv/rssi_charge_discharge_filter.sv -----
// ----------------------------------------------------------------------------
// rssi_charge_discharge_filter
// Clamped RSSI samples charge and discharge a Q1.FRAC_BITS quality level;
// outputs the level and its percent of the tracked peak.
// ----------------------------------------------------------------------------
// Program: each sample passes two alpha divisions of FRAC_BITS+1 steps and a
//   7-step percent division on one shared divider, plus twelve other steps;
//   the next sample is taken only once the last result has been emitted.
// A new sample is taken while a result waits; the program waits only at load
// for a sample and at emit for a free output register.
// Reset: level 0, peak about 0.01, ceiling 135, filter constant 1.0 (Q8.8).
// ----------------------------------------------------------------------------
module rssi_charge_discharge_filter
    import rcdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int LVL_W = FRAC_BITS + 1,
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((LVL_W + PCT_W + 7) / 8) * 8,
    localparam int CFG_W = (SAMPLE_BITS > FILTER_W) ? SAMPLE_BITS : FILTER_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // rssi_sample
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // quality_level, quality_percent
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [SAMPLE_BITS-1:0] ceiling_reg;
    logic [FILTER_W-1:0]    filter_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_free;
    ctrl_t                  ctrl;
    stat_t                  stat;
    logic                   div_more;
    logic [LVL_W-1:0]       out_level;
    logic [PCT_W-1:0]       out_pct;
    logic                   emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= SAMPLE_BITS'(CEILING_RESET);
            filter_reg  <= FILTER_W'(FILTER_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_CEILING:  ceiling_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_FILTER_CONSTANT: filter_reg  <= cfg_wdata[FILTER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign stat     = '{in_valid: s_tvalid, out_free: out_free, div_more: div_more};
    assign emit     = ctrl.en && (ctrl.op == OP_EMIT);
    assign s_tready = ctrl.op == OP_LOAD;

    rcdf_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rcdf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .sample_ceiling  (ceiling_reg),
        .filter_constant (filter_reg),
        .in_sample       (s_tdata[SAMPLE_BITS-1:0]),
        .div_more        (div_more),
        .out_level       (out_level),
        .out_pct         (out_pct)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= OUT_W'({out_pct, out_level});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // one sample at a time: no input transfer right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // emit never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwritten before transfer");

    // percent stays within range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LVL_W +: PCT_W] <= PCT_W'(PCT_MAX)))
        else $error("quality percent above 100");

endmodule

// ----- tb/tb_rssi_charge_discharge_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rssi_charge_discharge_filter
// Streams RSSI samples through the charge/discharge filter and checks every
// output level and percent against a cycle-free model kept in the bench.
// Covers several ceiling and RC settings, with and without bus idling.
// ----------------------------------------------------------------------------
module tb_rssi_charge_discharge_filter;
    import rcdf_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int LVL_W       = FRAC_BITS + 1;
    localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((LVL_W + PCT_W + 7) / 8) * 8;
    localparam int CFG_W       = (SAMPLE_BITS > FILTER_W) ? SAMPLE_BITS : FILTER_W;

    localparam logic [63:0] Q_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] Q_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] FLOOR_LEVEL = (Q_ONE + 64'd50) / 64'd100;

    localparam int LONG_HOLD    = 500;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [LVL_W-1:0] level;
    } quality_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;     // rssi_sample
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // quality_level, quality_percent
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // bench copy of filter state and configuration
    logic [SAMPLE_BITS-1:0] cfg_ceiling = SAMPLE_BITS'(CEILING_RESET);
    logic [FILTER_W-1:0]    cfg_rc = FILTER_W'(FILTER_RESET);
    logic [63:0]            filter_level = 64'd0;
    logic [63:0]            filter_peak = FLOOR_LEVEL;

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    quality_t               expected_quality[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int samples_in = 0;
    int results_out = 0;
    int mismatches = 0;
    int settings_run = 1;

    rssi_charge_discharge_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] alpha_q16(input logic [SAMPLE_BITS-1:0] x);
        logic [63:0] num;
        logic [63:0] den;
        num = 64'(x) * 64'd256;
        den = num + 64'(cfg_rc);
        // zero RC with zero width: divisor vanishes, alpha taken as zero
        if (den == 64'd0)
            return 64'd0;
        return (num << FRAC_BITS) / den;
    endfunction

    function automatic logic [63:0] mul_q16(input logic [63:0] a, input logic [63:0] b);
        return (a * b + Q_HALF) >> FRAC_BITS;
    endfunction

    task automatic advance_filter(input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS-1:0] on_w;
        logic [SAMPLE_BITS-1:0] off_w;
        logic [63:0] a_on;
        logic [63:0] a_off;
        logic [63:0] l1;
        logic [63:0] shown;
        logic [63:0] pct;
        quality_t    q;
        on_w  = (raw < cfg_ceiling) ? raw : cfg_ceiling;
        off_w = cfg_ceiling - on_w;
        a_on  = alpha_q16(on_w);
        a_off = alpha_q16(off_w);
        l1 = a_on + mul_q16(Q_ONE - a_on, filter_level);
        if (l1 > Q_ONE)
            l1 = Q_ONE;
        filter_level = mul_q16(Q_ONE - a_off, l1);
        if (filter_level > Q_ONE)
            filter_level = Q_ONE;
        if (filter_level > filter_peak)
            filter_peak = filter_level;
        shown = (filter_level <= FLOOR_LEVEL) ? 64'd0 : filter_level;
        pct = (shown * PCT_SCALE + filter_peak) / (64'd2 * filter_peak);
        if (pct > PCT_MAX)
            pct = PCT_MAX;
        q.level = shown[LVL_W-1:0];
        q.pct   = pct[PCT_W-1:0];
        expected_quality.push_back(q);
    endtask

    // ------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_filter(s_tdata[SAMPLE_BITS-1:0]);
                samples_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'(sample_queue.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready, with an on-demand long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input quality_t want,
                                   input quality_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected level %0d pct %0d, got level %0d pct %0d",
                     $realtime, what, want.level, want.pct, got.level, got.pct);
    endtask

    always @(posedge clk)
    begin
        quality_t got;
        quality_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = quality_t'(m_tdata[LVL_W+PCT_W-1:0]);
            results_out++;
            if (expected_quality.size() == 0)
                report_mismatch("unexpected transfer", '0, got);
            else
            begin
                want = expected_quality.pop_front();
                if (got.level != want.level || got.pct != want.pct)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb_rssi_charge_discharge_filter: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SAMPLE_CEILING)
            cfg_ceiling = data[SAMPLE_BITS-1:0];
        else
            cfg_rc = data[FILTER_W-1:0];
    endtask

    // wait until every queued sample went in and every result came out
    task automatic drain();
        while (sample_queue.size() != 0 || s_tvalid || expected_quality.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int sel;
        int c;
        sel = $urandom_range(99);
        if (sel < 35)
            return SAMPLE_BITS'($urandom);
        else if (sel < 65)
            return SAMPLE_BITS'($urandom_range(int'(cfg_ceiling)));
        else if (sel < 85)
        begin
            c = int'(cfg_ceiling) + int'($urandom_range(4)) - 2;
            if (c < 0)
                c = 0;
            if (c > 1023)
                c = 1023;
            return SAMPLE_BITS'(c);
        end
        else
        begin
            sel = $urandom_range(2);
            if (sel == 0)
                return '0;
            else if (sel == 1)
                return '1;
            return cfg_ceiling;
        end
    endfunction

    // bursts of similar samples push the level to its rails and back
    task automatic fill_random(input int n);
        int count;
        int burst;
        logic [SAMPLE_BITS-1:0] base;
        count = 0;
        while (count < n)
        begin
            burst = $urandom_range(16, 1);
            base = pick_sample();
            for (int i = 0; i < burst && count < n; i++)
            begin
                sample_queue.push_back(($urandom_range(3) == 0) ? pick_sample() : base);
                count++;
            end
        end
    endtask

    initial
    begin
        logic [SAMPLE_BITS-1:0] ceil_v;
        logic [FILTER_W-1:0]    rc_v;
        int mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: reset settings, field extremes, around the ceiling,
        // charge to the top and discharge below the display floor
        sample_queue = {10'd0, 10'd1023, 10'd135, 10'd134, 10'd136, 10'd1,
                        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd512,
                        10'd0, 10'd0, 10'd0, 10'd0};
        drain();

        // zero ceiling via a write with high junk bits: level must hold
        cfg_write(REG_SAMPLE_CEILING, 16'hFC00);
        settings_run++;
        sample_queue = {10'd1023, 10'd0, 10'd500};
        drain();

        // zero RC: alpha snaps to full scale, zero-width gives zero alpha
        cfg_write(REG_SAMPLE_CEILING, CFG_W'(1023));
        cfg_write(REG_FILTER_CONSTANT, '0);
        settings_run++;
        sample_queue = {10'd0, 10'd1023, 10'd1, 10'd512, 10'd0};
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin ceil_v = 10'd135;  rc_v = 16'd256;   end
                1:       begin ceil_v = 10'd1;    rc_v = 16'd1;     end
                2:       begin ceil_v = 10'd1023; rc_v = 16'hFFFF;  end
                3:       begin ceil_v = 10'd1023; rc_v = 16'd1;     end
                4:       begin ceil_v = 10'd1;    rc_v = 16'hFFFF;  end
                5:       begin ceil_v = 10'd135;  rc_v = 16'd0;     end
                8:       begin ceil_v = 10'($urandom_range(20, 1));
                               rc_v = 16'($urandom_range(65535, 1)); end
                9:       begin ceil_v = 10'($urandom_range(1023, 1));
                               rc_v = 16'($urandom_range(300, 1)); end
                default: begin ceil_v = 10'($urandom_range(1023, 1));
                               rc_v = 16'($urandom_range(65535, 1)); end
            endcase
            cfg_write(REG_SAMPLE_CEILING, {6'($urandom), ceil_v});
            cfg_write(REG_FILTER_CONSTANT, rc_v);
            settings_run++;

            mode = p % 4;
            src_idle_pct  = (mode == 1) ? 64 : (mode == 3) ? 14 : 0;
            snk_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 14 : 0;
            fill_random(PHASE_ITEMS);
            if (p == 0)
            begin
                // output held off while samples keep coming: input backs up
                repeat (120) @(posedge clk);
                hold_requests++;
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (expected_quality.size() != 0)
            mismatches++;
        $display("run: %0d samples, %0d results checked, %0d filter settings",
                 samples_in, results_out, settings_run);
        $display("run: zero ceiling and zero RC, bus idling mixes, one long output hold-off");
        if (mismatches == 0)
            $display("tb_rssi_charge_discharge_filter: done, clean");
        else
            $display("tb_rssi_charge_discharge_filter: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rcdf_pkg.sv
sv/rcdf_div.sv
sv/rcdf_datapath.sv
sv/rcdf_sequencer.sv
sv/rssi_charge_discharge_filter.sv
tb/tb_rssi_charge_discharge_filter.sv
